// ----- rtl/svdc_pkg.sv -----
// ----------------------------------------------------------------------------
// svdc_pkg
// Types, constants and a helper function shared by the SVPWM duty unit.
// ----------------------------------------------------------------------------
package svdc_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 31;
  localparam int IN_DATA_W     = 160;
  localparam int OUT_DATA_W    = 48;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_VCOMP_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UDC_NOM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADTIME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_SLOPE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_SWAP = 3'd5;

  // Window codes.
  localparam logic [1:0] WIN_W = 2'd0;
  localparam logic [1:0] WIN_U = 2'd1;
  localparam logic [1:0] WIN_V = 2'd2;

  typedef struct packed {
    logic        voltage_comp_enable;
    logic [30:0] udc_nominal;
    logic [7:0]  deadtime_counts;
    logic [30:0] comp_slope;
    logic [15:0] pwm_period;
    logic        phase_swap;
  } cfg_t;

  // One classified item as it sits in the queue.
  typedef struct packed {
    logic signed [31:0] va;
    logic signed [31:0] vb;
    logic signed [31:0] ia;
    logic signed [31:0] ib;
    logic [30:0]        bus;
    logic [30:0]        low;   // low 31 dividend bits, consumed MSB first
    logic [31:0]        rem;   // starting partial remainder
    logic               sat;   // ratio saturates (includes a zero bus reading)
  } item_t;

  // sqrt(3)/2 rounded to f fraction bits.
  function automatic logic [31:0] sqrt3_half(input int f);
    logic [63:0] t;
    t = (64'hDDB3D742C265539D >> (63 - f)) + 64'd1;
    return t[32:1];
  endfunction

endpackage

// ----- rtl/svdc_front.sv -----
// ----------------------------------------------------------------------------
// svdc_front
// Accepts input beats and prepares the bus-voltage division for the back end.
// ----------------------------------------------------------------------------
module svdc_front #(
  parameter int FRAC_BITS = svdc_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  svdc_pkg::cfg_t                  cfg,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [svdc_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            push,
  output svdc_pkg::item_t                 push_item,
  input  logic                            q_full
);

  logic            fvalid;
  svdc_pkg::item_t item;
  svdc_pkg::item_t item_next;
  logic [61:0]     lhs;
  logic [61:0]     rhs;

  assign s_tready  = !fvalid || !q_full;
  assign push      = fvalid && !q_full;
  assign push_item = item;

  always_comb begin
    lhs = 62'(cfg.udc_nominal) << FRAC_BITS;
    rhs = 62'(s_tdata[94:64]) << 31;
    item_next.va  = s_tdata[31:0];
    item_next.vb  = s_tdata[63:32];
    item_next.bus = s_tdata[94:64];
    item_next.ia  = s_tdata[126:95];
    item_next.ib  = s_tdata[158:127];
    // When the quotient fits in 31 bits, the upper dividend bits are below
    // the divisor and serve directly as the first partial remainder.
    item_next.sat = (lhs >= rhs);
    item_next.rem = 32'(cfg.udc_nominal >> (31 - FRAC_BITS));
    item_next.low = lhs[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (s_tready) begin
      fvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_next;
    end
  end

endmodule

// ----- rtl/svdc_queue.sv -----
// ----------------------------------------------------------------------------
// svdc_queue
// Short FIFO between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module svdc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  svdc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output svdc_pkg::item_t head_item
);

  localparam int PW = $clog2(svdc_pkg::QUEUE_DEPTH);

  svdc_pkg::item_t  slots [svdc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_pop;

  assign full       = (count == (PW+1)'(svdc_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/svdc_back.sv -----
// ----------------------------------------------------------------------------
// svdc_back
// Pipelined divider, voltage scaling, min-max injection, dead-time
// compensation and compare-value generation, with an output register.
// ----------------------------------------------------------------------------
module svdc_back #(
  parameter int FRAC_BITS = svdc_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  svdc_pkg::cfg_t                  cfg,
  input  logic                            head_valid,
  input  svdc_pkg::item_t                 head_item,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [svdc_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int NDIV = 31;
  localparam int LW   = FRAC_BITS + 1;
  localparam logic signed [31:0] K    = svdc_pkg::sqrt3_half(FRAC_BITS);
  localparam logic signed [35:0] QH   = 36'(1) << (FRAC_BITS - 1);
  localparam logic signed [35:0] Q1   = 36'(1) << FRAC_BITS;
  localparam logic signed [65:0] RND  = 66'(1) << (FRAC_BITS - 1);
  localparam logic [LW-1:0]      ONEL = LW'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] va;
    logic signed [31:0] vb;
    logic signed [31:0] ia;
    logic signed [31:0] ib;
    logic [30:0]        bus;
    logic [30:0]        low;
    logic [31:0]        rem;
    logic [30:0]        q;
    logic               sat;
  } div_t;

  function automatic div_t div_step(input div_t d);
    div_t        r;
    logic [31:0] t;
    r = d;
    t = {d.rem[30:0], d.low[30]};
    if (t >= {1'b0, d.bus}) begin
      r.rem = t - {1'b0, d.bus};
      r.q   = {d.q[29:0], 1'b1};
    end else begin
      r.rem = t;
      r.q   = {d.q[29:0], 1'b0};
    end
    r.low = {d.low[29:0], 1'b0};
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] s;
    s = x >>> FRAC_BITS;
    if (s > 64'sh7FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (s < -64'sh80000000) begin
      return -32'sh80000000;
    end
    return s[31:0];
  endfunction

  logic en;
  assign en  = !m_tvalid || m_tready;
  assign pop = en && head_valid;

  // Divider stages.
  div_t dv    [NDIV+1];
  logic dvld  [NDIV+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld[0] <= 1'b0;
    end else if (en) begin
      dvld[0] <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].va  <= head_item.va;
      dv[0].vb  <= head_item.vb;
      dv[0].ia  <= head_item.ia;
      dv[0].ib  <= head_item.ib;
      dv[0].bus <= head_item.bus;
      dv[0].low <= head_item.low;
      dv[0].rem <= head_item.rem;
      dv[0].sat <= head_item.sat;
      dv[0].q   <= '0;
    end
  end

  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[k] <= 1'b0;
      end else if (en) begin
        dvld[k] <= dvld[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k] <= div_step(dv[k-1]);
      end
    end
  end

  logic [8:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[7:1], dvld[NDIV]};
      m_tvalid <= vld[8];
    end
  end

  // Stage 1: scaling products and beta current product.
  logic [30:0]        ratio;
  logic signed [63:0] m1_pva, m1_pvb, m1_pib;
  logic signed [31:0] m1_va, m1_vb, m1_ia, m1_hai;

  assign ratio = dv[NDIV].sat ? 31'h7FFFFFFF : dv[NDIV].q;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_pva <= dv[NDIV].va * $signed({1'b0, ratio});
      m1_pvb <= dv[NDIV].vb * $signed({1'b0, ratio});
      m1_pib <= dv[NDIV].ib * K;
      m1_va  <= dv[NDIV].va;
      m1_vb  <= dv[NDIV].vb;
      m1_ia  <= dv[NDIV].ia;
      m1_hai <= dv[NDIV].ia >>> 1;
    end
  end

  // Stage 2: saturated scaled command (unscaled when voltage compensation is off), phase currents.
  logic signed [31:0] m2_va, m2_vb;
  logic signed [33:0] m2_ca, m2_cb, m2_cc;
  logic signed [63:0] sbi_full;
  logic signed [33:0] sbi;

  always_comb begin
    sbi_full = m1_pib >>> FRAC_BITS;
    sbi      = sbi_full[33:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_va <= cfg.voltage_comp_enable ? sat32(m1_pva) : m1_va;
      m2_vb <= cfg.voltage_comp_enable ? sat32(m1_pvb) : m1_vb;
      m2_ca <= 34'(m1_ia);
      m2_cb <= sbi - 34'(m1_hai);
      m2_cc <= -sbi - 34'(m1_hai);
    end
  end

  // Stage 3: beta voltage product, trapezoidal products.
  logic signed [63:0] m3_pvb;
  logic signed [31:0] m3_va, m3_hav;
  logic signed [33:0] m3_ca, m3_cb, m3_cc;
  logic signed [65:0] m3_ta, m3_tb, m3_tc;
  logic signed [31:0] slope_s;

  assign slope_s = $signed({1'b0, cfg.comp_slope});

  always_ff @(posedge clk) begin
    if (en) begin
      m3_pvb <= m2_vb * K;
      m3_va  <= m2_va;
      m3_hav <= m2_va >>> 1;
      m3_ca  <= m2_ca;
      m3_cb  <= m2_cb;
      m3_cc  <= m2_cc;
      m3_ta  <= m2_ca * slope_s;
      m3_tb  <= m2_cb * slope_s;
      m3_tc  <= m2_cc * slope_s;
    end
  end

  // Stage 4: phase voltages and compensation terms.
  function automatic logic signed [8:0] comp_of(input logic signed [33:0] cur,
                                                input logic signed [65:0] prod,
                                                input logic [7:0] dt,
                                                input logic slope_zero);
    logic signed [65:0] s;
    logic signed [65:0] dts;
    s   = (prod + RND) >>> FRAC_BITS;
    dts = 66'(dt);
    if (dt == 8'd0) begin
      return 9'sd0;
    end else if (slope_zero) begin
      if (cur > 34'sd0) begin
        return $signed({1'b0, dt});
      end else if (cur < 34'sd0) begin
        return -$signed({1'b0, dt});
      end
      return 9'sd0;
    end else if (s > dts) begin
      return $signed({1'b0, dt});
    end else if (s < -dts) begin
      return -$signed({1'b0, dt});
    end
    return s[8:0];
  endfunction

  logic signed [33:0] m4_pa, m4_pb, m4_pc;
  logic signed [8:0]  m4_ka, m4_kb, m4_kc;
  logic signed [63:0] sbv_full;
  logic signed [33:0] sbv;
  logic               slope_zero;

  assign slope_zero = (cfg.comp_slope == '0);

  always_comb begin
    sbv_full = m3_pvb >>> FRAC_BITS;
    sbv      = sbv_full[33:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m4_pa <= 34'(m3_va);
      m4_pb <= sbv - 34'(m3_hav);
      m4_pc <= -sbv - 34'(m3_hav);
      m4_ka <= comp_of(m3_ca, m3_ta, cfg.deadtime_counts, slope_zero);
      m4_kb <= comp_of(m3_cb, m3_tb, cfg.deadtime_counts, slope_zero);
      m4_kc <= comp_of(m3_cc, m3_tc, cfg.deadtime_counts, slope_zero);
    end
  end

  // Stage 5: zero-sequence offset from max and min.
  logic signed [33:0] m5_pa, m5_pb, m5_pc, m5_vz;
  logic signed [8:0]  m5_ka, m5_kb, m5_kc;
  logic signed [33:0] mx, mn;
  logic signed [34:0] mxn;

  always_comb begin
    mx = (m4_pa > m4_pb) ? ((m4_pa > m4_pc) ? m4_pa : m4_pc)
                         : ((m4_pb > m4_pc) ? m4_pb : m4_pc);
    mn = (m4_pa < m4_pb) ? ((m4_pa < m4_pc) ? m4_pa : m4_pc)
                         : ((m4_pb < m4_pc) ? m4_pb : m4_pc);
    mxn = 35'(mx) + 35'(mn);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m5_pa <= m4_pa;
      m5_pb <= m4_pb;
      m5_pc <= m4_pc;
      m5_vz <= mxn[34:1];
      m5_ka <= m4_ka;
      m5_kb <= m4_kb;
      m5_kc <= m4_kc;
    end
  end

  // Stage 6: clamped phase levels, phase swap.
  function automatic logic [LW-1:0] level_of(input logic signed [33:0] p,
                                             input logic signed [33:0] vz);
    logic signed [35:0] d;
    d = QH + (36'(p) - 36'(vz));
    if (d < 36'sd0) begin
      return '0;
    end else if (d > Q1) begin
      return ONEL;
    end
    return d[LW-1:0];
  endfunction

  logic [LW-1:0]     m6_lu, m6_lv, m6_lw;
  logic signed [8:0] m6_ku, m6_kv, m6_kw;
  logic [LW-1:0]     la, lb, lc;

  always_comb begin
    la = level_of(m5_pa, m5_vz);
    lb = level_of(m5_pb, m5_vz);
    lc = level_of(m5_pc, m5_vz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m6_lv <= lb;
      m6_kv <= m5_kb;
      if (cfg.phase_swap) begin
        m6_lu <= lc;
        m6_ku <= m5_kc;
        m6_lw <= la;
        m6_kw <= m5_ka;
      end else begin
        m6_lu <= la;
        m6_ku <= m5_ka;
        m6_lw <= lc;
        m6_kw <= m5_kc;
      end
    end
  end

  // Stage 7: (1 - level) * half.
  logic [14:0]         half;
  logic [LW+14:0]      m7_pu, m7_pv, m7_pw;
  logic signed [8:0]   m7_ku, m7_kv, m7_kw;

  assign half = cfg.pwm_period[15:1];

  always_ff @(posedge clk) begin
    if (en) begin
      m7_pu <= (ONEL - m6_lu) * half;
      m7_pv <= (ONEL - m6_lv) * half;
      m7_pw <= (ONEL - m6_lw) * half;
      m7_ku <= m6_ku;
      m7_kv <= m6_kv;
      m7_kw <= m6_kw;
    end
  end

  // Stage 8: subtract compensation, clamp to [0, half].
  function automatic logic [14:0] duty_of(input logic [LW+14:0] p,
                                          input logic signed [8:0] k,
                                          input logic [14:0] h);
    logic signed [16:0] d;
    d = $signed({2'b00, p[FRAC_BITS+14:FRAC_BITS]}) - 17'(k);
    if (d < 17'sd0) begin
      return '0;
    end else if (d > $signed({2'b00, h})) begin
      return h;
    end
    return d[14:0];
  endfunction

  logic [14:0] m8_du, m8_dv, m8_dw;

  always_ff @(posedge clk) begin
    if (en) begin
      m8_du <= duty_of(m7_pu, m7_ku, half);
      m8_dv <= duty_of(m7_pv, m7_kv, half);
      m8_dw <= duty_of(m7_pw, m7_kw, half);
    end
  end

  // Output register with sampling window.
  logic [1:0] win;

  always_comb begin
    if (m8_du >= m8_dv && m8_du >= m8_dw) begin
      win = svdc_pkg::WIN_U;
    end else if (m8_dv >= m8_dw) begin
      win = svdc_pkg::WIN_V;
    end else begin
      win = svdc_pkg::WIN_W;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, win, m8_dw, m8_dv, m8_du};
    end
  end

endmodule

// ----- rtl/svpwm_deadtime_comp_duty_unit.sv -----
// ----------------------------------------------------------------------------
// svpwm_deadtime_comp_duty_unit
// Space-vector PWM compare generator with dead-time compensation.
// Path: an accepted input beat passes the front-end register, the queue,
// the one-bit-per-stage bus-voltage divider and the back-end stages to m_tvalid.
// Throughput: one beat per cycle, limited only by m_tready.
// Reset: synchronous rst empties the pipeline and queue and loads the
// register defaults (compensation on, nominal 1.0, period 10000).
// ----------------------------------------------------------------------------
module svpwm_deadtime_comp_duty_unit #(
  parameter int FRAC_BITS = svdc_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata: v_alpha[31:0], v_beta[63:32], bus_voltage[94:64],
  //          i_alpha[126:95], i_beta[158:127], zero pad
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [svdc_pkg::IN_DATA_W-1:0]   s_tdata,
  // m_tdata: duty_u[14:0], duty_v[29:15], duty_w[44:30],
  //          sample_window[46:45], zero pad
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [svdc_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             cfg_we,
  input  logic [svdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [svdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  svdc_pkg::cfg_t  cfg;
  svdc_pkg::item_t push_item;
  svdc_pkg::item_t head_item;
  logic            push;
  logic            q_full;
  logic            pop;
  logic            head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.voltage_comp_enable <= 1'b1;
      cfg.udc_nominal         <= 31'd16777216;
      cfg.deadtime_counts     <= 8'd0;
      cfg.comp_slope          <= 31'd0;
      cfg.pwm_period          <= 16'd10000;
      cfg.phase_swap          <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        svdc_pkg::REG_VCOMP_EN:   cfg.voltage_comp_enable <= cfg_data[0];
        svdc_pkg::REG_UDC_NOM:    cfg.udc_nominal         <= cfg_data;
        svdc_pkg::REG_DEADTIME:   cfg.deadtime_counts     <= cfg_data[7:0];
        svdc_pkg::REG_COMP_SLOPE: cfg.comp_slope          <= cfg_data;
        svdc_pkg::REG_PWM_PERIOD: cfg.pwm_period          <= cfg_data[15:0];
        svdc_pkg::REG_PHASE_SWAP: cfg.phase_swap          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  svdc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  svdc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  svdc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
